// ===== design/dblm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual battery level monitor package
// Shared widths, codes, configuration and lane/merge result types.
// ----------------------------------------------------------------------------
`default_nettype none

package dblm_pkg;

  // Number of readings kept per channel for the moving average.
  localparam int AVG_DEPTH = 16;

  localparam int SMP_W  = 12;
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = $clog2(AVG_DEPTH * 4095 + 1);

  // Percentage arithmetic: |avg - empty| * 100 fits in NUM_W bits.
  localparam int PCT_W     = 7;
  localparam int PCT_SCALE = 100;
  localparam int NUM_W     = 19;
  localparam int PCT_STEPS = 7;
  localparam int AVG_STEPS = SMP_W;
  localparam int STEP_W    = 4;

  // Level codes.
  localparam logic [2:0] LVL_UNKNOWN    = 3'd0;
  localparam logic [2:0] LVL_HIGH       = 3'd1;
  localparam logic [2:0] LVL_MEDIUM     = 3'd2;
  localparam logic [2:0] LVL_LOW        = 3'd3;
  localparam logic [2:0] LVL_IMBALANCED = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FULL_THRESHOLD      = 3'd0;
  localparam logic [2:0] CFG_LOW_THRESHOLD       = 3'd1;
  localparam logic [2:0] CFG_IMBALANCE_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_IMBALANCE_NEEDED    = 3'd3;
  localparam logic [2:0] CFG_SKIP_TICKS          = 3'd4;
  localparam logic [2:0] CFG_ADC_EMPTY           = 3'd5;
  localparam logic [2:0] CFG_ADC_FULL            = 3'd6;
  localparam logic [2:0] CFG_BLINK_INTERVAL_MS   = 3'd7;

  typedef struct packed {
    logic [11:0] full_threshold;
    logic [11:0] low_threshold;
    logic [11:0] imbalance_threshold;
    logic [7:0]  imbalance_needed;
    logic [15:0] skip_ticks;
    logic [11:0] adc_empty;
    logic [11:0] adc_full;
    logic [15:0] blink_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [SMP_W-1:0] avg;
    logic [PCT_W-1:0] pct;
  } lane_res_t;

  typedef struct packed {
    logic [2:0] level;
    logic       red;
    logic       green;
  } merge_res_t;

endpackage

`default_nettype wire

// ===== design/dblm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery channel lane
// Ring buffer, running sum, serial average divider and percentage divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dblm_lane (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [dblm_pkg::SMP_W-1:0]   sample,
  input  wire logic [dblm_pkg::SLOT_W-1:0]  slot,
  input  wire logic                         filled,
  input  wire logic [dblm_pkg::CNT_W-1:0]   count,
  input  wire dblm_pkg::cfg_t               cfg,
  output dblm_pkg::lane_res_t               res
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_AVG  = 3'd1;
  localparam logic [2:0] L_PMUL = 3'd2;
  localparam logic [2:0] L_PCMP = 3'd3;
  localparam logic [2:0] L_PDIV = 3'd4;
  localparam logic [2:0] L_DONE = 3'd5;

  logic [2:0]                   state_r;
  logic [dblm_pkg::SMP_W-1:0]   ring_r [dblm_pkg::AVG_DEPTH];
  logic [dblm_pkg::SUM_W-1:0]   sum_r;
  logic [dblm_pkg::SUM_W-1:0]   sum_nxt;
  logic [dblm_pkg::SMP_W-1:0]   old_sample;
  logic [dblm_pkg::CNT_W-1:0]   div_r;
  logic [dblm_pkg::CNT_W-1:0]   rem_r;
  logic [dblm_pkg::SMP_W-1:0]   dvd_r;
  logic [dblm_pkg::STEP_W-1:0]  step_r;
  logic [dblm_pkg::CNT_W:0]     trial;
  logic                         trial_ge;
  logic [dblm_pkg::SMP_W-1:0]   avg_r;
  logic [dblm_pkg::PCT_W-1:0]   pct_r;

  logic [dblm_pkg::SMP_W:0]     num_diff;
  logic [dblm_pkg::SMP_W:0]     den_diff;
  logic [dblm_pkg::SMP_W-1:0]   num_mag;
  logic [dblm_pkg::SMP_W-1:0]   den_mag;
  logic [dblm_pkg::NUM_W-1:0]   num100_r;
  logic [dblm_pkg::SMP_W-1:0]   den_r;
  logic                         pzero_r;
  logic                         peq_r;
  logic                         pge_r;
  logic [dblm_pkg::NUM_W-1:0]   den100;
  logic [dblm_pkg::NUM_W-1:0]   prem_r;
  logic [dblm_pkg::NUM_W-1:0]   dsh_r;

  // Entries past the fill count were never written and read as zero.
  assign old_sample = filled ? ring_r[slot] : '0;
  assign sum_nxt    = sum_r - dblm_pkg::SUM_W'(old_sample) + dblm_pkg::SUM_W'(sample);

  assign trial    = {rem_r, dvd_r[dblm_pkg::SMP_W-1]};
  assign trial_ge = trial >= {1'b0, div_r};

  assign num_diff = {1'b0, dvd_r} - {1'b0, cfg.adc_empty};
  assign den_diff = {1'b0, cfg.adc_full} - {1'b0, cfg.adc_empty};
  assign num_mag  = num_diff[dblm_pkg::SMP_W] ? dblm_pkg::SMP_W'(-num_diff)
                                              : num_diff[dblm_pkg::SMP_W-1:0];
  assign den_mag  = den_diff[dblm_pkg::SMP_W] ? dblm_pkg::SMP_W'(-den_diff)
                                              : den_diff[dblm_pkg::SMP_W-1:0];
  assign den100   = dblm_pkg::NUM_W'(den_r) * dblm_pkg::NUM_W'(dblm_pkg::PCT_SCALE);

  always_ff @(posedge clk) begin
    if (start) begin
      ring_r[slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      sum_r   <= '0;
    end else begin
      case (state_r)
        L_AVG: begin
          rem_r  <= trial_ge ? dblm_pkg::CNT_W'(trial - {1'b0, div_r})
                             : dblm_pkg::CNT_W'(trial);
          dvd_r  <= {dvd_r[dblm_pkg::SMP_W-2:0], trial_ge};
          step_r <= step_r + 1'b1;
          if (step_r == dblm_pkg::STEP_W'(dblm_pkg::AVG_STEPS - 1)) begin
            state_r <= L_PMUL;
          end
        end
        L_PMUL: begin
          avg_r    <= dvd_r;
          num100_r <= dblm_pkg::NUM_W'(num_mag) * dblm_pkg::NUM_W'(dblm_pkg::PCT_SCALE);
          den_r    <= den_mag;
          pzero_r  <= (num_diff[dblm_pkg::SMP_W] != den_diff[dblm_pkg::SMP_W]) ||
                      (num_mag == '0);
          peq_r    <= (den_mag == '0);
          pge_r    <= !num_diff[dblm_pkg::SMP_W];
          state_r  <= L_PCMP;
        end
        L_PCMP: begin
          if (peq_r) begin
            pct_r   <= pge_r ? dblm_pkg::PCT_W'(dblm_pkg::PCT_SCALE) : '0;
            state_r <= L_DONE;
          end else if (pzero_r) begin
            pct_r   <= '0;
            state_r <= L_DONE;
          end else if (num100_r >= den100) begin
            pct_r   <= dblm_pkg::PCT_W'(dblm_pkg::PCT_SCALE);
            state_r <= L_DONE;
          end else begin
            prem_r  <= num100_r;
            dsh_r   <= dblm_pkg::NUM_W'(den_r) << (dblm_pkg::PCT_STEPS - 1);
            pct_r   <= '0;
            step_r  <= '0;
            state_r <= L_PDIV;
          end
        end
        L_PDIV: begin
          if (prem_r >= dsh_r) begin
            prem_r <= prem_r - dsh_r;
            pct_r  <= {pct_r[dblm_pkg::PCT_W-2:0], 1'b1};
          end else begin
            pct_r  <= {pct_r[dblm_pkg::PCT_W-2:0], 1'b0};
          end
          dsh_r  <= dsh_r >> 1;
          step_r <= step_r + 1'b1;
          if (step_r == dblm_pkg::STEP_W'(dblm_pkg::PCT_STEPS - 1)) begin
            state_r <= L_DONE;
          end
        end
        default: begin
          state_r <= state_r;
        end
      endcase
      // A new item may start from idle or after a finished one.
      if (start) begin
        sum_r   <= sum_nxt;
        rem_r   <= dblm_pkg::CNT_W'(sum_nxt >> dblm_pkg::SMP_W);
        dvd_r   <= sum_nxt[dblm_pkg::SMP_W-1:0];
        div_r   <= count;
        step_r  <= '0;
        state_r <= L_AVG;
      end
    end
  end

  assign res.done = (state_r == L_DONE);
  assign res.avg  = avg_r;
  assign res.pct  = pct_r;

endmodule

`default_nettype wire

// ===== design/dblm_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level classifier and indicator driver
// Combines both channel averages into a level code, imbalance run and LEDs.
// ----------------------------------------------------------------------------
`default_nettype none

module dblm_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        commit,
  input  wire logic [dblm_pkg::SMP_W-1:0]  avg_first,
  input  wire logic [dblm_pkg::SMP_W-1:0]  avg_second,
  input  wire logic [31:0]                 now_ms,
  input  wire dblm_pkg::cfg_t              cfg,
  output dblm_pkg::merge_res_t             res
);

  logic [7:0]                  run_r;
  logic [7:0]                  run_nxt;
  logic                        blink_r;
  logic                        blink_nxt;
  logic [31:0]                 last_r;
  logic [31:0]                 last_nxt;
  logic [2:0]                  base_level;
  logic [2:0]                  level;
  logic [dblm_pkg::SMP_W-1:0]  diff;
  logic                        imb;
  logic [31:0]                 elapsed;
  logic                        toggle;

  always_comb begin
    if (avg_first > cfg.full_threshold && avg_second > cfg.full_threshold) begin
      base_level = dblm_pkg::LVL_HIGH;
    end else if (avg_first > cfg.low_threshold && avg_second > cfg.low_threshold) begin
      base_level = dblm_pkg::LVL_MEDIUM;
    end else begin
      base_level = dblm_pkg::LVL_LOW;
    end

    diff = (avg_first > avg_second) ? avg_first - avg_second : avg_second - avg_first;
    imb  = diff > cfg.imbalance_threshold;

    // The run saturates at the needed count; only then is imbalance reported.
    run_nxt = run_r;
    level   = base_level;
    if (imb) begin
      if (run_r < cfg.imbalance_needed) begin
        run_nxt = run_r + 8'd1;
      end else if (base_level != dblm_pkg::LVL_LOW) begin
        level = dblm_pkg::LVL_IMBALANCED;
      end
    end else begin
      run_nxt = '0;
    end

    elapsed   = now_ms - last_r;
    toggle    = (level == dblm_pkg::LVL_IMBALANCED) &&
                (elapsed >= {16'd0, cfg.blink_interval_ms});
    blink_nxt = toggle ? !blink_r : blink_r;
    last_nxt  = toggle ? now_ms : last_r;

    res.level = level;
    case (level)
      dblm_pkg::LVL_HIGH: begin
        res.red   = 1'b0;
        res.green = 1'b1;
      end
      dblm_pkg::LVL_MEDIUM: begin
        res.red   = 1'b1;
        res.green = 1'b1;
      end
      dblm_pkg::LVL_LOW: begin
        res.red   = 1'b1;
        res.green = 1'b0;
      end
      default: begin
        res.red   = blink_nxt;
        res.green = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      blink_r <= 1'b0;
      last_r  <= '0;
    end else if (commit) begin
      run_r   <= run_nxt;
      blink_r <= blink_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/dual_battery_level_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual battery level monitor
// Moving-average level monitor for two batteries with imbalance detection.
// ----------------------------------------------------------------------------
// Each input item is one loop tick with a reading per battery and a
// millisecond time; every item yields exactly one result item. Only one tick
// in skip_ticks is processed: the others return level code 0 at once, with
// the averages, percentages and LEDs of the last processed tick. A processed
// tick is handled by the two channel lanes working side by side: each runs a
// 12-step serial divider for its moving average (running sum over the readings
// held so far) and up to a 7-step serial divider for its 0..100 percentage,
// after which the level classifier settles the level code and LEDs
// combinationally, ahead of the output register.
// A skipped tick is answered in the cycle after it is accepted. Results
// wait in an output register, so a processed tick may be accepted while
// the previous result has not yet been taken. Configuration may be written
// whenever the block is idle; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_battery_level_monitor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [11:0] sample_first, [23:12] sample_second, [55:24] now_ms
  input  wire logic [55:0] in_tdata,
  // Result items.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] level_code, [3] led_red, [4] led_green, [16:5] average_first,
  // [28:17] average_second, [35:29] percent_first, [42:36] percent_second,
  // [47:43] zero
  output logic [47:0]      out_tdata,
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  dblm_pkg::cfg_t                cfg_r;
  logic [1:0]                    state_r;
  logic [15:0]                   tick_r;
  logic [15:0]                   tick_nxt;
  logic                          proc_now;
  logic                          in_acc;
  logic                          start;
  logic [dblm_pkg::SLOT_W-1:0]   slot_r;
  logic [dblm_pkg::CNT_W-1:0]    count_r;
  logic [dblm_pkg::CNT_W-1:0]    count_nxt;
  logic                          filled;
  logic [31:0]                   now_r;
  logic                          out_free;
  logic                          commit;
  logic                          out_valid_r;
  logic [2:0]                    out_level_r;
  logic                          held_red_r;
  logic                          held_green_r;
  logic [dblm_pkg::SMP_W-1:0]    held_avg1_r;
  logic [dblm_pkg::SMP_W-1:0]    held_avg2_r;
  logic [dblm_pkg::PCT_W-1:0]    held_pct1_r;
  logic [dblm_pkg::PCT_W-1:0]    held_pct2_r;
  dblm_pkg::lane_res_t           lane1_res;
  dblm_pkg::lane_res_t           lane2_res;
  dblm_pkg::merge_res_t          merge_res;

  // Tick counting: a tick is processed when the incremented count reaches
  // skip_ticks, so a skip_ticks of zero processes every tick.
  assign tick_nxt = tick_r + 16'd1;
  assign proc_now = tick_nxt >= cfg_r.skip_ticks;

  // The output register is free when empty or being drained this cycle.
  assign out_free  = !out_valid_r || out_tready;
  // A skipped tick needs the output register right away; a processed tick
  // only needs it at the end, so it may enter while a result still waits.
  assign in_tready = (state_r == ST_IDLE) && (proc_now || out_free);
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && proc_now;
  assign commit    = (state_r == ST_COMMIT) && out_free;

  // Until the ring has wrapped, the slot about to be overwritten is empty.
  assign filled    = (count_r == dblm_pkg::CNT_W'(dblm_pkg::AVG_DEPTH));
  assign count_nxt = filled ? count_r : count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_threshold      <= 12'd3000;
      cfg_r.low_threshold       <= 12'd2600;
      cfg_r.imbalance_threshold <= 12'd18;
      cfg_r.imbalance_needed    <= 8'd5;
      cfg_r.skip_ticks          <= 16'd1;
      cfg_r.adc_empty           <= 12'd0;
      cfg_r.adc_full            <= 12'd4095;
      cfg_r.blink_interval_ms   <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        dblm_pkg::CFG_FULL_THRESHOLD:      cfg_r.full_threshold      <= cfg_wdata[11:0];
        dblm_pkg::CFG_LOW_THRESHOLD:       cfg_r.low_threshold       <= cfg_wdata[11:0];
        dblm_pkg::CFG_IMBALANCE_THRESHOLD: cfg_r.imbalance_threshold <= cfg_wdata[11:0];
        dblm_pkg::CFG_IMBALANCE_NEEDED:    cfg_r.imbalance_needed    <= cfg_wdata[7:0];
        dblm_pkg::CFG_SKIP_TICKS:          cfg_r.skip_ticks          <= cfg_wdata;
        dblm_pkg::CFG_ADC_EMPTY:           cfg_r.adc_empty           <= cfg_wdata[11:0];
        dblm_pkg::CFG_ADC_FULL:            cfg_r.adc_full            <= cfg_wdata[11:0];
        dblm_pkg::CFG_BLINK_INTERVAL_MS:   cfg_r.blink_interval_ms   <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_r       <= '0;
      slot_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      out_level_r  <= dblm_pkg::LVL_UNKNOWN;
      held_red_r   <= 1'b0;
      held_green_r <= 1'b0;
      held_avg1_r  <= '0;
      held_avg2_r  <= '0;
      held_pct1_r  <= '0;
      held_pct2_r  <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (proc_now) begin
              tick_r  <= '0;
              now_r   <= in_tdata[55:24];
              count_r <= count_nxt;
              if (slot_r == dblm_pkg::SLOT_W'(dblm_pkg::AVG_DEPTH - 1)) begin
                slot_r <= '0;
              end else begin
                slot_r <= slot_r + 1'b1;
              end
              state_r <= ST_BUSY;
            end else begin
              // Skipped tick: the held fields already sit on the output.
              tick_r      <= tick_nxt;
              out_level_r <= dblm_pkg::LVL_UNKNOWN;
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_BUSY: begin
          if (lane1_res.done && lane2_res.done) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit) begin
            out_level_r  <= merge_res.level;
            held_red_r   <= merge_res.red;
            held_green_r <= merge_res.green;
            held_avg1_r  <= lane1_res.avg;
            held_avg2_r  <= lane2_res.avg;
            held_pct1_r  <= lane1_res.pct;
            held_pct2_r  <= lane2_res.pct;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  dblm_lane u_lane_first (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sample (in_tdata[11:0]),
    .slot   (slot_r),
    .filled (filled),
    .count  (count_nxt),
    .cfg    (cfg_r),
    .res    (lane1_res)
  );

  dblm_lane u_lane_second (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sample (in_tdata[23:12]),
    .slot   (slot_r),
    .filled (filled),
    .count  (count_nxt),
    .cfg    (cfg_r),
    .res    (lane2_res)
  );

  dblm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .avg_first  (lane1_res.avg),
    .avg_second (lane2_res.avg),
    .now_ms     (now_r),
    .cfg        (cfg_r),
    .res        (merge_res)
  );

  // The held fields only change when a new result is loaded, so they form
  // the stable payload of the output register together with the level code.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, held_pct2_r, held_pct1_r, held_avg2_r, held_avg1_r,
                       held_green_r, held_red_r, out_level_r};

endmodule

`default_nettype wire
